// ===== design/pidp_pkg.sv =====
package pidp_pkg;

  localparam int POS_W_DEF  = 32;
  localparam int TIME_W_DEF = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIM  = 3'd5;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd2048;
  localparam logic [23:0] DERIV_GAIN_RST = 24'd30000;
  localparam logic [31:0] INTEG_GAIN_RST = 32'd0;
  localparam logic [7:0]  MAX_POWER_RST  = 8'd120;
  localparam logic [7:0]  MIN_POWER_RST  = 8'd50;
  localparam logic [7:0]  STALL_LIM_RST  = 8'd100;

  // shared multiplier and accumulator
  localparam int MUL_AW = 48;
  localparam int MUL_BW = 16;
  localparam int ACC_W  = 80;

  // derivative dividend: 58-bit product shifted left by 8
  localparam int DIV_NW = 66;

  localparam logic [46:0]       INTEG_LIMIT = '1;
  localparam logic [DIV_NW-1:0] D_LIMIT     = 66'd1 << 60;

endpackage

// ===== design/pidp_div.sv =====
module pidp_div #(
  parameter int NW = pidp_pkg::DIV_NW,
  parameter int VW = pidp_pkg::TIME_W_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  import pidp_pkg::*;

  localparam int CNT_W = $clog2(NW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    rem_r;
  logic [NW-1:0]    quo_r;
  logic [VW-1:0]    dvs_r;
  logic [VW:0]      trial;
  logic             fits;

  // restoring step, one quotient bit per cycle
  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
        quo_r <= {quo_r[NW-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/pid_position_motor_control_unit.sv =====
// Position PID controller for a DC motor. Each request is either a begin-move
// (loads the target, clears history) or a control tick carrying the encoder
// position and elapsed microseconds; every request yields exactly one drive
// result. Requests are processed one at a time: in_ready is high only while the
// controller is idle. A begin-move, a tick with no move active and a tick that
// ends the move (arrival or stall) go from the check straight to the output state;
// a regular control tick also runs the 66-step serial divider for the derivative
// term and seven passes through the shared 48x16 multiplier. A result held in the
// output register does not block acceptance of the next request.
module pid_position_motor_control_unit #(
  parameter int POSITION_WIDTH = pidp_pkg::POS_W_DEF,
  parameter int TIME_WIDTH     = pidp_pkg::TIME_W_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pidp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic signed [POSITION_WIDTH-1:0]      in_target_pos,
  input  logic signed [POSITION_WIDTH-1:0]      in_position,
  input  logic [TIME_WIDTH-1:0]                 in_elapsed_us,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            out_pwm_duty,
  output logic                                  out_direction,
  output logic                                  out_move_done,
  output logic                                  out_stalled
);
  import pidp_pkg::*;

  localparam int P = POSITION_WIDTH;
  localparam int T = TIME_WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_MP   = 4'd2;
  localparam logic [3:0] S_MD0  = 4'd3;
  localparam logic [3:0] S_MD1  = 4'd4;
  localparam logic [3:0] S_DGO  = 4'd5;
  localparam logic [3:0] S_DWT  = 4'd6;
  localparam logic [3:0] S_MI0  = 4'd7;
  localparam logic [3:0] S_MI1  = 4'd8;
  localparam logic [3:0] S_INT  = 4'd9;
  localparam logic [3:0] S_MG0  = 4'd10;
  localparam logic [3:0] S_MG1  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  logic [15:0] prop_gain_r;
  logic [23:0] deriv_gain_r;
  logic [31:0] integ_gain_r;
  logic [7:0]  max_power_r, min_power_r, stall_lim_r;

  logic signed [P-1:0] goal_r, last_r, pos_r, tgt_r;
  logic signed [P:0]   prev_err_r;
  logic signed [47:0]  integ_r;
  logic [8:0]          same_r;
  logic                active_r;
  logic                cmd_r;
  logic [T-1:0]        el_r;

  logic [P:0]          e_mag_r;
  logic                e_neg_r;
  logic [P+1:0]        de_mag_r;
  logic                de_neg_r;
  logic signed [63:0]  p_term_r, d_term_r;
  logic [ACC_W-1:0]    acc_r;

  logic [7:0] res_duty_r;
  logic       res_dir_r, res_done_r, res_stall_r;
  logic       out_valid_r;
  logic [7:0] out_duty_r;
  logic       out_dir_r, out_done_r, out_stall_r;

  // tick checks
  logic signed [P:0]   e_w;
  logic signed [P+1:0] de_w;
  logic [P:0]          e_mag_w;
  logic [P+1:0]        de_mag_w;
  logic [8:0]          same_w;

  assign e_w      = {pos_r[P-1], pos_r} - {goal_r[P-1], goal_r};
  assign de_w     = {e_w[P], e_w} - {prev_err_r[P], prev_err_r};
  assign e_mag_w  = e_w[P] ? (~e_w + 1'b1) : e_w;
  assign de_mag_w = de_w[P+1] ? (~de_w + 1'b1) : de_w;
  assign same_w   = (pos_r == last_r) ? ((same_r == 9'h1FF) ? same_r : same_r + 1'b1)
                                      : 9'd0;

  // shared multiplier
  logic [MUL_AW-1:0]        mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic [MUL_AW+MUL_BW-1:0] prod;
  logic [31:0]              el_ext;
  logic [47:0]              integ_mag;

  assign el_ext    = 32'(el_r);
  assign integ_mag = integ_r[47] ? 48'(-integ_r) : 48'(integ_r);

  always_comb begin
    mul_a = MUL_AW'(e_mag_r);
    mul_b = prop_gain_r;
    case (state_r)
      S_MD0: begin
        mul_a = MUL_AW'(de_mag_r);
        mul_b = deriv_gain_r[15:0];
      end
      S_MD1: begin
        mul_a = MUL_AW'(de_mag_r);
        mul_b = {8'd0, deriv_gain_r[23:16]};
      end
      S_MI0: mul_b = el_ext[15:0];
      S_MI1: mul_b = el_ext[31:16];
      S_MG0: begin
        mul_a = integ_mag;
        mul_b = integ_gain_r[15:0];
      end
      S_MG1: begin
        mul_a = integ_mag;
        mul_b = integ_gain_r[31:16];
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // serial divider for the derivative term
  logic              div_start;
  logic              div_done;
  logic [DIV_NW-1:0] div_q;
  logic [DIV_NW-1:0] dm_w;

  assign div_start = (state_r == S_DGO);
  assign dm_w      = (div_q > D_LIMIT) ? D_LIMIT : div_q;

  pidp_div #(
    .NW(DIV_NW),
    .VW(T)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({acc_r[57:0], 8'd0}),
    .divisor  (el_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // integral update
  logic [46:0]        step_mag;
  logic signed [48:0] step_s, isum, lim_pos, lim_neg;

  assign step_mag = (acc_r[ACC_W-1:47] != '0) ? INTEG_LIMIT : acc_r[46:0];
  assign step_s   = e_neg_r ? -$signed({2'b00, step_mag}) : $signed({2'b00, step_mag});
  assign isum     = {integ_r[47], integ_r} + step_s;
  assign lim_pos  = $signed({2'b00, INTEG_LIMIT});
  assign lim_neg  = -lim_pos;

  // final sum and drive shaping
  logic [55:0]        im;
  logic signed [63:0] i_term, u;
  logic [63:0]        um;
  logic [55:0]        dq;
  logic [7:0]         dcap;

  assign im     = acc_r[79:24];
  assign i_term = integ_r[47] ? -$signed(64'(im)) : $signed(64'(im));
  assign u      = p_term_r + d_term_r + i_term;
  assign um     = u[63] ? 64'(-u) : 64'(u);
  assign dq     = um[63:8];
  assign dcap   = (dq > 56'(max_power_r)) ? max_power_r : dq[7:0];

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CHK;
      S_CHK: begin
        if (!cmd_r || !active_r) state_nxt = S_OUT;
        else if (pos_r == goal_r || same_w > {1'b0, stall_lim_r}) state_nxt = S_OUT;
        else state_nxt = S_MP;
      end
      S_MP:  state_nxt = S_MD0;
      S_MD0: state_nxt = S_MD1;
      S_MD1: state_nxt = S_DGO;
      S_DGO: state_nxt = S_DWT;
      S_DWT: if (div_done) state_nxt = S_MI0;
      S_MI0: state_nxt = S_MI1;
      S_MI1: state_nxt = S_INT;
      S_INT: state_nxt = S_MG0;
      S_MG0: state_nxt = S_MG1;
      S_MG1: state_nxt = S_FIN;
      S_FIN: state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prop_gain_r  <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      max_power_r  <= MAX_POWER_RST;
      min_power_r  <= MIN_POWER_RST;
      stall_lim_r  <= STALL_LIM_RST;
      goal_r       <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      last_r       <= '1;
      same_r       <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[15:0];
          REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata[23:0];
          REG_INTEG_GAIN: integ_gain_r <= cfg_wdata[31:0];
          REG_MAX_POWER:  max_power_r  <= cfg_wdata[7:0];
          REG_MIN_POWER:  min_power_r  <= cfg_wdata[7:0];
          REG_STALL_LIM:  stall_lim_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            tgt_r <= in_target_pos;
            pos_r <= in_position;
            el_r  <= (in_elapsed_us == '0) ? T'(1) : in_elapsed_us;
          end
        end
        S_CHK: begin
          res_duty_r  <= '0;
          res_dir_r   <= 1'b0;
          res_done_r  <= 1'b0;
          res_stall_r <= 1'b0;
          if (!cmd_r) begin
            goal_r     <= tgt_r;
            prev_err_r <= '0;
            integ_r    <= '0;
            last_r     <= '1;
            same_r     <= '0;
            active_r   <= 1'b1;
          end else if (!active_r) begin
            res_done_r <= 1'b1;
          end else begin
            last_r <= pos_r;
            if (pos_r == goal_r || same_w > {1'b0, stall_lim_r}) begin
              res_done_r  <= 1'b1;
              res_stall_r <= (pos_r != goal_r);
              same_r      <= '0;
              active_r    <= 1'b0;
            end else begin
              same_r     <= same_w;
              e_mag_r    <= e_mag_w;
              e_neg_r    <= e_w[P];
              de_mag_r   <= de_mag_w;
              de_neg_r   <= de_w[P+1];
              prev_err_r <= e_w;
            end
          end
        end
        S_MP: p_term_r <= e_neg_r ? -$signed(64'(prod)) : $signed(64'(prod));
        S_MD0, S_MI0, S_MG0: acc_r <= ACC_W'(prod);
        S_MD1, S_MI1, S_MG1: acc_r <= acc_r + {prod, 16'd0};
        S_DWT: begin
          if (div_done) d_term_r <= de_neg_r ? -$signed(64'(dm_w)) : $signed(64'(dm_w));
        end
        S_INT: begin
          if (isum > lim_pos) integ_r <= lim_pos[47:0];
          else if (isum < lim_neg) integ_r <= lim_neg[47:0];
          else integ_r <= isum[47:0];
        end
        S_FIN: begin
          res_duty_r <= (dcap < min_power_r) ? 8'd0 : dcap;
          res_dir_r  <= u[63];
        end
        S_OUT: begin
          if (out_free) begin
            out_duty_r  <= res_duty_r;
            out_dir_r   <= res_dir_r;
            out_done_r  <= res_done_r;
            out_stall_r <= res_stall_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pwm_duty  = out_duty_r;
  assign out_direction = out_dir_r;
  assign out_move_done = out_done_r;
  assign out_stalled   = out_stall_r;

endmodule

// ===== design/pidp_chk.sv =====
module pidp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pwm_duty,
  input logic       out_direction,
  input logic       out_move_done,
  input logic       out_stalled
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pwm_duty)
      && $stable(out_direction) && $stable(out_move_done) && $stable(out_stalled))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a request");

  a_stall_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stalled |-> out_move_done)
    else $error("stall flagged without move end");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> out_pwm_duty == 8'd0 && !out_direction)
    else $error("drive nonzero on finished move");

endmodule

bind pid_position_motor_control_unit pidp_chk u_pidp_chk (.*);

// ===== verif/pid_position_motor_control_unit_tb.sv =====
module pid_position_motor_control_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 120;
  localparam bit CMD_BEGIN = 1'b0;
  localparam bit CMD_TICK  = 1'b1;
  localparam longint unsigned INTEG_LIM = (64'd1 << 47) - 1;
  localparam longint unsigned DRV_LIM   = 64'd1 << 60;

  typedef struct packed {
    logic [7:0] duty;
    logic       dir;
    logic       done;
    logic       stl;
  } drive_t;

  typedef struct {
    bit          cmd;
    logic [31:0] tgt;
    logic [31:0] pos;
    logic [23:0] el;
    bit          typed;
    drive_t      res;
  } stim_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_command;
  logic signed [31:0] in_target_pos, in_position;
  logic [23:0] in_elapsed_us;
  logic out_valid, out_ready;
  logic [7:0] out_pwm_duty;
  logic out_direction, out_move_done, out_stalled;

  pid_position_motor_control_unit dut (.*);

  // controller shadow
  logic [15:0] kp;
  logic [23:0] kd;
  logic [31:0] ki;
  logic [7:0]  pmax, pmin, slim;
  longint goal_r, prev_err_r, integ_r, last_pos_r;
  int     same_r;
  bit     active_r;

  drive_t drive_q[$];
  int errors, n_reqs, n_results, n_done, n_stalled, n_driven;
  bit hold_req, no_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic void shadow_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_PROP_GAIN:  kp   = val[15:0];
      REG_DERIV_GAIN: kd   = val[23:0];
      REG_INTEG_GAIN: ki   = val;
      REG_MAX_POWER:  pmax = val[7:0];
      REG_MIN_POWER:  pmin = val[7:0];
      REG_STALL_LIM:  slim = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic drive_t predict_drive(bit cmd, logic [31:0] tgt, logic [31:0] pos_in,
                                           logic [23:0] el_in);
    drive_t r;
    longint pos, e, de, u;
    longint unsigned el, m, q, rm, dm, a, b, im, um, drv;
    r = '0;
    if (cmd == CMD_BEGIN) begin
      goal_r = longint'($signed(tgt));
      prev_err_r = 0;
      integ_r = 0;
      last_pos_r = -1;
      same_r = 0;
      active_r = 1'b1;
      return r;
    end
    if (!active_r) begin
      r.done = 1'b1;
      return r;
    end
    pos = longint'($signed(pos_in));
    el = el_in;
    if (el == 0) el = 1;
    if (pos == last_pos_r) begin
      if (same_r < 511) same_r++;
    end else begin
      last_pos_r = pos;
      same_r = 0;
    end
    if (pos == goal_r || same_r > int'(slim)) begin
      r.done = 1'b1;
      r.stl = (pos != goal_r);
      same_r = 0;
      active_r = 1'b0;
      return r;
    end
    e = pos - goal_r;
    de = e - prev_err_r;
    m = longint'(kd) * mag(de);
    q = m / el;
    rm = m % el;
    if (q >= (DRV_LIM >> 8)) dm = DRV_LIM;
    else begin
      dm = (q << 8) + ((rm << 8) / el);
      if (dm > DRV_LIM) dm = DRV_LIM;
    end
    u = with_sign(longint'(kp) * mag(e), e < 0) + with_sign(dm, de < 0);
    m = mag(e);
    if (m > INTEG_LIM / el) m = INTEG_LIM;
    else begin
      m = m * el;
      if (m > INTEG_LIM) m = INTEG_LIM;
    end
    integ_r += with_sign(m, e < 0);
    if (integ_r > longint'(INTEG_LIM)) integ_r = longint'(INTEG_LIM);
    if (integ_r < -longint'(INTEG_LIM)) integ_r = -longint'(INTEG_LIM);
    m = mag(integ_r);
    a = m * longint'(ki[31:16]);
    b = m * longint'(ki[15:0]);
    im = (a >> 8) + ((((a & 64'hff) << 16) + b) >> 24);
    u += with_sign(im, integ_r < 0);
    um = mag(u);
    drv = um >> 8;
    if (drv > pmax) drv = pmax;
    if (drv < pmin) drv = 0;
    prev_err_r = e;
    r.duty = drv[7:0];
    r.dir = (u < 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg(idx, val);
  endtask

  task automatic set_gains(logic [15:0] p, logic [23:0] d, logic [31:0] i,
                           logic [7:0] hi, logic [7:0] lo, logic [7:0] st);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_MAX_POWER, hi);
    write_reg(REG_MIN_POWER, lo);
    write_reg(REG_STALL_LIM, st);
    write_reg(REG_UNUSED, $urandom);
    @(posedge clk);
  endtask

  task automatic send_request(bit cmd, logic [31:0] tgt, logic [31:0] pos,
                              logic [23:0] el, bit typed = 0, drive_t want = '0);
    int gap;
    drive_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_target_pos <= tgt;
    in_position <= pos;
    in_elapsed_us <= el;
    do @(posedge clk); while (!in_ready);
    pred = predict_drive(cmd, tgt, pos, el);
    drive_q.push_back(typed ? want : pred);
    n_reqs++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  // mostly coherent moves: approach, sit still, arrive; some noise
  task automatic run_moves(int n);
    int cnt, ticks, k;
    logic [31:0] tgt, pos;
    logic [23:0] el;
    cnt = 0;
    while (cnt < n) begin
      tgt = ($urandom_range(0, 3) == 0) ? $urandom : near(32'd0, 5000);
      if ($urandom_range(0, 9) != 0) begin
        send_request(CMD_BEGIN, tgt, $urandom, 24'($urandom));
        cnt++;
      end
      pos = ($urandom_range(0, 4) == 0) ? $urandom : near(tgt, 3000);
      ticks = $urandom_range(1, 12);
      for (k = 0; k < ticks; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pos = pos + ((tgt - pos) >>> $urandom_range(0, 3));
          4, 5:       ;
          6:          pos = tgt;
          7:          pos = $urandom;
          default:    pos = near(pos, 50);
        endcase
        case ($urandom_range(0, 7))
          0:       el = 24'd0;
          1:       el = 24'hffffff;
          2:       el = 24'($urandom);
          default: el = 24'($urandom_range(1, 20000));
        endcase
        send_request(CMD_TICK, $urandom, pos, el);
        cnt++;
      end
    end
  endtask

  stim_row_t directed[] = '{
    '{CMD_TICK,  32'd0,        32'd0,        24'd100,     1, '{8'd0, 1'b0, 1'b1, 1'b0}},
    '{CMD_BEGIN, 32'd100,      32'd0,        24'd0,       1, '{8'd0, 1'b0, 1'b0, 1'b0}},
    '{CMD_TICK,  32'd0,        32'd0,        24'd1000,    0, '0},
    '{CMD_TICK,  32'd0,        32'd0,        24'd0,       0, '0},
    '{CMD_TICK,  32'd0,        32'd300,      24'd1,       0, '0},
    '{CMD_TICK,  32'd0,        32'd100,      24'd500,     1, '{8'd0, 1'b0, 1'b1, 1'b0}},
    '{CMD_TICK,  32'd0,        32'd7,        24'd500,     1, '{8'd0, 1'b0, 1'b1, 1'b0}},
    '{CMD_BEGIN, 32'h7fffffff, 32'hffffffff, 24'hffffff,  1, '{8'd0, 1'b0, 1'b0, 1'b0}},
    '{CMD_TICK,  32'hffffffff, 32'h80000000, 24'hffffff,  0, '0},
    '{CMD_TICK,  32'd0,        32'h80000000, 24'd0,       0, '0},
    '{CMD_TICK,  32'd0,        32'h7ffffffe, 24'd1,       0, '0},
    '{CMD_BEGIN, 32'h80000000, 32'd0,        24'd0,       1, '{8'd0, 1'b0, 1'b0, 1'b0}},
    '{CMD_TICK,  32'd0,        32'h7fffffff, 24'd1,       0, '0},
    '{CMD_TICK,  32'd0,        32'h80000001, 24'd3,       0, '0},
    '{CMD_BEGIN, 32'd5,        32'd0,        24'd0,       1, '{8'd0, 1'b0, 1'b0, 1'b0}},
    '{CMD_TICK,  32'd0,        32'hffffffff, 24'd10,      0, '0},
    '{CMD_TICK,  32'd0,        32'hffffffff, 24'd10,      0, '0},
    '{CMD_TICK,  32'd0,        32'd2,        24'd40,      0, '0},
    '{CMD_TICK,  32'd0,        32'd5,        24'd40,      1, '{8'd0, 1'b0, 1'b1, 1'b0}}
  };

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = CMD_TICK;
    in_target_pos = '0;
    in_position = '0;
    in_elapsed_us = '0;
    out_ready = 1'b0;
    kp = PROP_GAIN_RST;
    kd = DERIV_GAIN_RST;
    ki = INTEG_GAIN_RST;
    pmax = MAX_POWER_RST;
    pmin = MIN_POWER_RST;
    slim = STALL_LIM_RST;
    goal_r = 0;
    prev_err_r = 0;
    integ_r = 0;
    last_pos_r = -1;
    same_r = 0;
    active_r = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].cmd, directed[i].tgt, directed[i].pos, directed[i].el,
                   directed[i].typed, directed[i].res);
    run_moves(60);
    wait_drained();

    set_gains(16'd4000, 24'd200000, 32'd50000, 8'd255, 8'd0, 8'd0);
    hold_req = 1'b1;
    run_moves(60);
    wait_drained();

    set_gains(16'hffff, 24'hffffff, 32'hffffffff, 8'd255, 8'd1, 8'd255);
    no_idle = 1'b1;
    run_moves(60);
    no_idle = 1'b0;
    wait_drained();

    set_gains(16'd0, 24'd0, 32'd0, 8'd0, 8'd255, 8'd3);
    run_moves(50);
    wait_drained();

    set_gains(16'd300, 24'd5000, 32'd4294, 8'd40, 8'd90, 8'd2);
    run_moves(50);
    wait_drained();

    set_gains(16'($urandom), 24'($urandom), $urandom, 8'($urandom_range(60, 255)),
              8'($urandom_range(0, 60)), 8'($urandom_range(0, 6)));
    run_moves(100);
    wait_drained();

    $display("Covered %0d requests, %0d results: %0d ended (%0d stalled), %0d driven",
             n_reqs, n_results, n_done, n_stalled, n_driven);
    $display("over six gain/limit settings incl. all-zero and all-max, with a long output hold");
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin : receiver
    int stall;
    drive_t want;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_results++;
      if (drive_q.size() == 0) begin
        errors++;
        $display("[%0t] result with no request pending", $realtime);
      end else begin
        want = drive_q.pop_front();
        if (out_pwm_duty !== want.duty) report_mismatch("pwm_duty", out_pwm_duty, want.duty);
        if (out_direction !== want.dir) report_mismatch("direction", out_direction, want.dir);
        if (out_move_done !== want.done) report_mismatch("move_done", out_move_done, want.done);
        if (out_stalled !== want.stl) report_mismatch("stalled", out_stalled, want.stl);
      end
      if (out_move_done === 1'b1) n_done++;
      if (out_stalled === 1'b1) n_stalled++;
      if (out_pwm_duty != 0) n_driven++;
    end
  end

  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

endmodule
